>>> design/tpc_pkg.sv
// ----------------------------------------------------------------------------
// TCP checksum package
// Shared constants, register indexes, types and word-sum helpers for the
// TCP pseudo-header checksum block.
// ----------------------------------------------------------------------------
package tpc_pkg;

  localparam int LENGTH_BITS_DEF = 16;
  localparam int CFG_IDX_W       = 3;
  localparam int CFG_DATA_W      = 64;
  localparam int LEN_W           = 16;
  localparam int SUM_W           = 32;
  localparam int PRE_W           = 21;
  localparam int PROTO_W         = 8;
  localparam logic [PROTO_W-1:0] PROTO_RESET = 8'd6;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IPV6_MODE = 3'd0,
    CFG_SRC_UPPER = 3'd1,
    CFG_SRC_LOWER = 3'd2,
    CFG_DST_UPPER = 3'd3,
    CFG_DST_LOWER = 3'd4,
    CFG_PROTOCOL  = 3'd5
  } cfg_idx_t;

  typedef struct packed {
    logic [SUM_W-1:0] sum;
    logic [LEN_W-1:0] len;
    logic             ovf;
  } seg_result_t;

  function automatic logic [17:0] words64(input logic [63:0] v);
    words64 = 18'(v[15:0]) + 18'(v[31:16]) + 18'(v[47:32]) + 18'(v[63:48]);
  endfunction

  function automatic logic [16:0] words32(input logic [31:0] v);
    words32 = 17'(v[15:0]) + 17'(v[31:16]);
  endfunction

endpackage

>>> design/tcp_pseudo_header_checksum.sv
// ----------------------------------------------------------------------------
// TCP pseudo-header checksum
// Computes the TCP checksum of a byte stream, including the IPv4 or IPv6
// pseudo-header, and reports the segment length.
// ----------------------------------------------------------------------------
// The block takes one segment byte per clock, but holds off a final byte while
// the holding stage is full and the output is stalled. The 32-bit accumulator
// adds each byte into its running sum, and the pseudo-header add and carry
// folding sit in a later stage, so bytes of the next segment flow in while the
// previous result is folded or waits at the output. The last byte's sum passes
// the holding register and then the output register before a result appears.
// The address and protocol words are summed into a register in the cycle after
// a configuration write, so the first byte may follow any write directly.
module tcp_pseudo_header_checksum #(
  parameter int LENGTH_BITS = tpc_pkg::LENGTH_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [tpc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tpc_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [7:0]                     in_segment_byte,
  input  logic                           in_final_byte,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [15:0]                    out_checksum_value,
  output logic [tpc_pkg::LEN_W-1:0]      out_segment_length,
  output logic                           out_length_overflow
);
  import tpc_pkg::*;

  logic [PRE_W-1:0] pre_sum;
  logic             b_valid;
  seg_result_t      b_res;
  logic             c_free;

  tpc_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .pre_sum   (pre_sum)
  );

  tpc_acc #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_acc (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_segment_byte (in_segment_byte),
    .in_final_byte   (in_final_byte),
    .b_valid         (b_valid),
    .b_res           (b_res),
    .c_free          (c_free)
  );

  tpc_fold #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_fold (
    .clk                 (clk),
    .rst_n               (rst_n),
    .b_valid             (b_valid),
    .b_res               (b_res),
    .pre_sum             (pre_sum),
    .c_free              (c_free),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_checksum_value  (out_checksum_value),
    .out_segment_length  (out_segment_length),
    .out_length_overflow (out_length_overflow)
  );

endmodule

>>> design/tpc_cfg.sv
// ----------------------------------------------------------------------------
// TCP checksum configuration registers
// Holds the address, mode and protocol registers and keeps a registered
// sum of the address words and the protocol number.
// ----------------------------------------------------------------------------
module tpc_cfg (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [tpc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tpc_pkg::CFG_DATA_W-1:0] cfg_data,
  output logic [tpc_pkg::PRE_W-1:0]      pre_sum
);
  import tpc_pkg::*;

  logic                  ipv6_r;
  logic [63:0]           src_upper_r;
  logic [63:0]           src_lower_r;
  logic [63:0]           dst_upper_r;
  logic [63:0]           dst_lower_r;
  logic [PROTO_W-1:0]    proto_r;
  logic [PRE_W-1:0]      pre_r;
  logic [PRE_W-1:0]      pre_nxt;
  logic                  wr_en;

  assign cfg_ready = 1'b1;
  assign wr_en     = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ipv6_r      <= 1'b0;
      src_upper_r <= '0;
      src_lower_r <= '0;
      dst_upper_r <= '0;
      dst_lower_r <= '0;
      proto_r     <= PROTO_RESET;
    end else if (wr_en) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_IPV6_MODE: ipv6_r      <= cfg_data[0];
        CFG_SRC_UPPER: src_upper_r <= cfg_data;
        CFG_SRC_LOWER: src_lower_r <= cfg_data;
        CFG_DST_UPPER: dst_upper_r <= cfg_data;
        CFG_DST_LOWER: dst_lower_r <= cfg_data;
        CFG_PROTOCOL:  proto_r     <= cfg_data[PROTO_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (ipv6_r) begin
      pre_nxt = PRE_W'(words64(src_upper_r)) + PRE_W'(words64(src_lower_r))
              + PRE_W'(words64(dst_upper_r)) + PRE_W'(words64(dst_lower_r))
              + PRE_W'(proto_r);
    end else begin
      pre_nxt = PRE_W'(words32(src_lower_r[31:0])) + PRE_W'(words32(dst_lower_r[31:0]))
              + PRE_W'(proto_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pre_r <= PRE_W'(PROTO_RESET);
    end else begin
      pre_r <= pre_nxt;
    end
  end

  assign pre_sum = pre_r;

endmodule

>>> design/tpc_acc.sv
// ----------------------------------------------------------------------------
// TCP checksum byte accumulator
// Input register, running 32-bit sum and saturating byte counter, and a
// stage that holds the finished sum of a segment until the fold stage
// takes it.
// ----------------------------------------------------------------------------
module tpc_acc #(
  parameter int LENGTH_BITS = tpc_pkg::LENGTH_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [7:0]           in_segment_byte,
  input  logic                 in_final_byte,
  output logic                 b_valid,
  output tpc_pkg::seg_result_t b_res,
  input  logic                 c_free
);
  import tpc_pkg::*;

  localparam logic [LENGTH_BITS-1:0] CNT_MAX = '1;

  logic [7:0]             byte_r;
  logic                   final_r;
  logic                   a_valid_r;
  logic                   a_valid_nxt;
  logic                   a_go;
  logic                   a_load;
  logic [SUM_W-1:0]       sum_r;
  logic [SUM_W-1:0]       sum_nxt;
  logic [SUM_W-1:0]       sum_upd;
  logic [SUM_W-1:0]       addend;
  logic [LENGTH_BITS-1:0] cnt_r;
  logic [LENGTH_BITS-1:0] cnt_nxt;
  logic [LENGTH_BITS-1:0] cnt_upd;
  logic                   ovf_r;
  logic                   ovf_nxt;
  logic                   ovf_upd;
  logic                   at_max;
  logic                   b_free;
  logic                   b_valid_r;
  logic                   b_valid_nxt;
  seg_result_t            b_res_r;

  assign b_free   = !b_valid_r || c_free;
  assign a_go     = a_valid_r && (!final_r || b_free);
  assign in_stall = a_valid_r && !a_go;
  assign a_load   = in_valid && !in_stall;

  always_comb begin
    a_valid_nxt = a_valid_r;
    if (a_load) begin
      a_valid_nxt = 1'b1;
    end else if (a_go) begin
      a_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else begin
      a_valid_r <= a_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (a_load) begin
      byte_r  <= in_segment_byte;
      final_r <= in_final_byte;
    end
  end

  assign addend  = cnt_r[0] ? {24'd0, byte_r} : {16'd0, byte_r, 8'd0};
  assign sum_upd = sum_r + addend;
  assign at_max  = (cnt_r == CNT_MAX);
  assign cnt_upd = at_max ? cnt_r : cnt_r + 1'b1;
  assign ovf_upd = ovf_r || at_max;

  always_comb begin
    sum_nxt = sum_r;
    cnt_nxt = cnt_r;
    ovf_nxt = ovf_r;
    if (a_go) begin
      if (final_r) begin
        sum_nxt = '0;
        cnt_nxt = '0;
        ovf_nxt = 1'b0;
      end else begin
        sum_nxt = sum_upd;
        cnt_nxt = cnt_upd;
        ovf_nxt = ovf_upd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r <= '0;
      cnt_r <= '0;
      ovf_r <= 1'b0;
    end else begin
      sum_r <= sum_nxt;
      cnt_r <= cnt_nxt;
      ovf_r <= ovf_nxt;
    end
  end

  always_comb begin
    b_valid_nxt = b_valid_r;
    if (a_go && final_r) begin
      b_valid_nxt = 1'b1;
    end else if (c_free) begin
      b_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
    end else begin
      b_valid_r <= b_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (a_go && final_r) begin
      b_res_r.sum <= sum_upd;
      b_res_r.len <= LEN_W'(cnt_upd);
      b_res_r.ovf <= ovf_upd;
    end
  end

  assign b_valid = b_valid_r;
  assign b_res   = b_res_r;

  a_final_clears: assert property (@(posedge clk) disable iff (!rst_n)
    a_go && final_r |=> (sum_r == '0) && (cnt_r == '0) && !ovf_r)
    else $error("accumulator not cleared after the last byte");

  a_ovf_at_max: assert property (@(posedge clk) disable iff (!rst_n)
    ovf_r |-> at_max)
    else $error("overflow flag set below the counter maximum");

  a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
    b_valid_r && !c_free |=> b_valid_r)
    else $error("finished segment sum dropped while the fold stage was busy");

endmodule

>>> design/tpc_fold.sv
// ----------------------------------------------------------------------------
// TCP checksum fold stage
// Adds the pseudo-header to a finished segment sum, folds the carries
// twice, inverts and registers the result for the output transfer.
// ----------------------------------------------------------------------------
module tpc_fold #(
  parameter int LENGTH_BITS = tpc_pkg::LENGTH_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         b_valid,
  input  tpc_pkg::seg_result_t         b_res,
  input  logic [tpc_pkg::PRE_W-1:0]    pre_sum,
  output logic                         c_free,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [15:0]                  out_checksum_value,
  output logic [tpc_pkg::LEN_W-1:0]    out_segment_length,
  output logic                         out_length_overflow
);
  import tpc_pkg::*;

  localparam logic [LENGTH_BITS-1:0] CNT_MAX = '1;

  logic               b_go;
  logic               out_valid_r;
  logic               out_valid_nxt;
  logic [SUM_W-1:0]   total;
  logic [16:0]        fold1;
  logic [16:0]        fold2;
  logic [15:0]        inv;
  logic [15:0]        csum_nxt;
  logic [15:0]        csum_r;
  logic [LEN_W-1:0]   len_r;
  logic               ovf_r;

  assign c_free = !out_valid_r || !out_stall;
  assign b_go   = b_valid && c_free;

  assign total    = b_res.sum + SUM_W'(pre_sum) + SUM_W'(b_res.len);
  assign fold1    = 17'(total[15:0]) + 17'(total[31:16]);
  assign fold2    = 17'(fold1[15:0]) + 17'(fold1[16]);
  assign inv      = ~fold2[15:0];
  assign csum_nxt = (inv == 16'h0000) ? 16'hFFFF : inv;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (b_go) begin
      out_valid_nxt = 1'b1;
    end else if (c_free) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (b_go) begin
      csum_r <= csum_nxt;
      len_r  <= b_res.len;
      ovf_r  <= b_res.ovf;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_checksum_value  = csum_r;
  assign out_segment_length  = len_r;
  assign out_length_overflow = ovf_r;

  a_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (csum_r != 16'h0000))
    else $error("checksum of zero presented");

  a_take_result: assert property (@(posedge clk) disable iff (!rst_n)
    b_valid && c_free |=> out_valid_r)
    else $error("segment sum taken but no result presented");

  a_ovf_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && ovf_r |-> (len_r == LEN_W'(CNT_MAX)))
    else $error("overflow reported with a length below the maximum");

endmodule

>>> test/tb_tcp_pseudo_header_checksum.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// TCP pseudo-header checksum testbench
// Streams segment bytes through the checksum block under IPv4 and IPv6
// settings, with random gaps and output stalls, and compares each result with
// a table row or a cycle-free prediction of ones' complement sum, length, flag.
// ----------------------------------------------------------------------------
module tb_tcp_pseudo_header_checksum;
  import tpc_pkg::*;

  typedef struct packed {
    logic [15:0]      csum;
    logic [LEN_W-1:0] len;
    logic             ovf;
  } seg_check_t;

  typedef struct packed {
    logic [7:0]       b;
    logic             fin;
    logic             has_exp;
    logic [15:0]      csum;
    logic [LEN_W-1:0] len;
    logic             ovf;
  } dir_row_t;

  localparam logic [LEN_W-1:0] SEG_COUNT_MAX = '1;
  localparam int               N_DIR_ROWS    = 20;

  localparam dir_row_t DIR_ROWS [N_DIR_ROWS] = '{
    '{8'h00, 1'b1, 1'b1, 16'hFFF8, 16'd1, 1'b0},
    '{8'hFF, 1'b1, 1'b1, 16'h00F8, 16'd1, 1'b0},
    '{8'hFF, 1'b0, 1'b0, 16'h0000, 16'd0, 1'b0},
    '{8'hFF, 1'b1, 1'b1, 16'hFFF7, 16'd2, 1'b0},
    '{8'hFF, 1'b0, 1'b0, 16'h0000, 16'd0, 1'b0},
    '{8'hF7, 1'b1, 1'b1, 16'hFFFF, 16'd2, 1'b0},
    '{8'h12, 1'b0, 1'b0, 16'h0000, 16'd0, 1'b0},
    '{8'h34, 1'b0, 1'b0, 16'h0000, 16'd0, 1'b0},
    '{8'h56, 1'b1, 1'b0, 16'h0000, 16'd0, 1'b0},
    '{8'hAA, 1'b0, 1'b0, 16'h0000, 16'd0, 1'b0},
    '{8'h55, 1'b0, 1'b0, 16'h0000, 16'd0, 1'b0},
    '{8'hAA, 1'b0, 1'b0, 16'h0000, 16'd0, 1'b0},
    '{8'h55, 1'b1, 1'b0, 16'h0000, 16'd0, 1'b0},
    '{8'h00, 1'b0, 1'b0, 16'h0000, 16'd0, 1'b0},
    '{8'h00, 1'b0, 1'b0, 16'h0000, 16'd0, 1'b0},
    '{8'h00, 1'b1, 1'b1, 16'hFFF6, 16'd3, 1'b0},
    '{8'h80, 1'b0, 1'b0, 16'h0000, 16'd0, 1'b0},
    '{8'h01, 1'b0, 1'b0, 16'h0000, 16'd0, 1'b0},
    '{8'h7F, 1'b0, 1'b0, 16'h0000, 16'd0, 1'b0},
    '{8'hFE, 1'b1, 1'b0, 16'h0000, 16'd0, 1'b0}
  };

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [7:0]            in_segment_byte = '0;
  logic                  in_final_byte = 1'b0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [15:0]           out_checksum_value;
  logic [LEN_W-1:0]      out_segment_length;
  logic                  out_length_overflow;

  logic                  row_has_exp = 1'b0;
  seg_check_t            row_exp = '0;
  logic                  hold_req = 1'b0;
  int                    hold_left = 0;
  int                    snd_idle_pct = 0;
  int                    rcv_idle_pct = 0;
  int                    n_errors = 0;

  logic                  ph_ipv6 = 1'b0;
  logic [63:0]           ph_src_hi = '0;
  logic [63:0]           ph_src_lo = '0;
  logic [63:0]           ph_dst_hi = '0;
  logic [63:0]           ph_dst_lo = '0;
  logic [PROTO_W-1:0]    ph_proto = PROTO_RESET;
  logic [SUM_W-1:0]      sum_acc = '0;
  logic [LEN_W-1:0]      seg_count = '0;
  logic                  seg_ovf = 1'b0;
  seg_check_t            pending_checks [$];

  tcp_pseudo_header_checksum u_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_segment_byte     (in_segment_byte),
    .in_final_byte       (in_final_byte),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_checksum_value  (out_checksum_value),
    .out_segment_length  (out_segment_length),
    .out_length_overflow (out_length_overflow)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic logic [31:0] half_word_sum(input logic [63:0] v, input int n);
    logic [31:0] s;
    s = '0;
    for (int i = 0; i < n; i++) s = s + 32'(v[16*i +: 16]);
    return s;
  endfunction

  function automatic void add_segment_byte(input logic [7:0] b, input logic fin,
                                           input logic typed, input seg_check_t typed_exp);
    logic [31:0] s;
    logic [15:0] c;
    seg_check_t  r;
    if (!seg_count[0]) sum_acc = sum_acc + {16'b0, b, 8'b0};
    else sum_acc = sum_acc + {24'b0, b};
    if (seg_count == SEG_COUNT_MAX) seg_ovf = 1'b1;
    else seg_count = seg_count + 1'b1;
    if (fin) begin
      s = sum_acc + 32'(ph_proto) + 32'(seg_count);
      if (ph_ipv6) begin
        s = s + half_word_sum(ph_src_hi, 4) + half_word_sum(ph_src_lo, 4)
              + half_word_sum(ph_dst_hi, 4) + half_word_sum(ph_dst_lo, 4);
      end else begin
        s = s + half_word_sum(ph_src_lo, 2) + half_word_sum(ph_dst_lo, 2);
      end
      s = {16'b0, s[15:0]} + {16'b0, s[31:16]};
      s = {16'b0, s[15:0]} + {16'b0, s[31:16]};
      c = ~s[15:0];
      if (c == 16'h0000) c = 16'hFFFF;
      r.csum = c;
      r.len  = seg_count;
      r.ovf  = seg_ovf;
      pending_checks.push_back(typed ? typed_exp : r);
      sum_acc   = '0;
      seg_count = '0;
      seg_ovf   = 1'b0;
    end
  endfunction

  always @(posedge clk) begin
    seg_check_t e;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_IPV6_MODE: ph_ipv6   = cfg_data[0];
          CFG_SRC_UPPER: ph_src_hi = cfg_data;
          CFG_SRC_LOWER: ph_src_lo = cfg_data;
          CFG_DST_UPPER: ph_dst_hi = cfg_data;
          CFG_DST_LOWER: ph_dst_lo = cfg_data;
          CFG_PROTOCOL:  ph_proto  = cfg_data[PROTO_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        add_segment_byte(in_segment_byte, in_final_byte, row_has_exp, row_exp);
      end
      if (out_valid && !out_stall) begin
        if (pending_checks.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual csum %h len %h ovf %b",
                   $time, out_checksum_value, out_segment_length, out_length_overflow);
          n_errors++;
        end else begin
          e = pending_checks.pop_front();
          if (out_checksum_value !== e.csum) begin
            $display("%0t: checksum mismatch, expected %h actual %h",
                     $time, e.csum, out_checksum_value);
            n_errors++;
          end
          if (out_segment_length !== e.len) begin
            $display("%0t: length mismatch, expected %h actual %h",
                     $time, e.len, out_segment_length);
            n_errors++;
          end
          if (out_length_overflow !== e.ovf) begin
            $display("%0t: overflow flag mismatch, expected %b actual %b",
                     $time, e.ovf, out_length_overflow);
            n_errors++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_req) begin
      out_stall <= 1'b1;
      hold_left <= 80;
    end else begin
      out_stall <= ($urandom_range(99, 0) < rcv_idle_pct);
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic fin,
                           input logic typed, input seg_check_t typed_exp);
    if ($urandom_range(99, 0) < snd_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_segment_byte <= b;
    in_final_byte   <= fin;
    row_has_exp     <= typed;
    row_exp         <= typed_exp;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic send_segments(input int n_bytes);
    int sent;
    int seg_len;
    sent = 0;
    while (sent < n_bytes) begin
      if ($urandom_range(19, 0) == 0) seg_len = $urandom_range(200, 17);
      else seg_len = $urandom_range(16, 1);
      for (int i = 0; i < seg_len; i++) begin
        send_byte(8'($urandom_range(255, 0)), i == seg_len - 1, 1'b0, '0);
      end
      sent += seg_len;
    end
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_checks.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic load_setting(input int k);
    logic [63:0] mode_w;
    logic [63:0] proto_w;
    logic [63:0] addr [4];
    mode_w  = {$urandom, $urandom};
    proto_w = {$urandom, $urandom};
    for (int i = 0; i < 4; i++) addr[i] = {$urandom, $urandom};
    case (k)
      0: begin
        mode_w  = '1;
        proto_w = '1;
        for (int i = 0; i < 4; i++) addr[i] = '1;
      end
      1: begin
        mode_w  = '0;
        proto_w = '0;
        for (int i = 0; i < 4; i++) addr[i] = '0;
      end
      2: begin
        mode_w  = 64'h0;
        proto_w = 64'hFF;
        for (int i = 0; i < 4; i++) addr[i] = '1;
      end
      3: begin
        mode_w  = 64'h1;
        proto_w = 64'h0;
        for (int i = 0; i < 4; i++) addr[i] = '0;
      end
      default: ;
    endcase
    write_reg(CFG_IPV6_MODE, mode_w);
    write_reg(CFG_SRC_UPPER, addr[0]);
    write_reg(CFG_SRC_LOWER, addr[1]);
    write_reg(CFG_DST_UPPER, addr[2]);
    write_reg(CFG_DST_LOWER, addr[3]);
    write_reg(CFG_PROTOCOL, proto_w);
    write_reg(CFG_IDX_W'($urandom_range(2**CFG_IDX_W - 1, int'(CFG_PROTOCOL) + 1)),
              {$urandom, $urandom});
    cfg_valid <= 1'b0;
  endtask

  initial begin
    seg_check_t typed_exp;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    snd_idle_pct = 15;
    rcv_idle_pct = 49;
    for (int i = 0; i < N_DIR_ROWS; i++) begin
      typed_exp.csum = DIR_ROWS[i].csum;
      typed_exp.len  = DIR_ROWS[i].len;
      typed_exp.ovf  = DIR_ROWS[i].ovf;
      send_byte(DIR_ROWS[i].b, DIR_ROWS[i].fin, DIR_ROWS[i].has_exp, typed_exp);
    end

    for (int p = 0; p < 3; p++) begin
      case (p)
        0: begin snd_idle_pct = 15; rcv_idle_pct = 49; end
        1: begin snd_idle_pct = 49; rcv_idle_pct = 15; end
        default: begin snd_idle_pct = 0; rcv_idle_pct = 0; end
      endcase
      for (int s = 0; s < 4; s++) begin
        drain_results();
        load_setting(p * 4 + s);
        if (p == 2 && s == 0) begin
          hold_req <= 1'b1;
          @(posedge clk);
          hold_req <= 1'b0;
          for (int i = 0; i < 40; i++) send_byte(8'($urandom_range(255, 0)), 1'b1, 1'b0, '0);
        end
        send_segments(60);
      end
    end

    drain_results();
    if (n_errors == 0 && pending_checks.size() == 0) begin
      $display("tb_tcp_pseudo_header_checksum: PASS");
    end else begin
      $display("tb_tcp_pseudo_header_checksum: FAIL");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("tb_tcp_pseudo_header_checksum: FAIL");
    $finish;
  end

endmodule

>>> filelist.f
design/tpc_pkg.sv
design/tpc_cfg.sv
design/tpc_acc.sv
design/tpc_fold.sv
design/tcp_pseudo_header_checksum.sv
test/tb_tcp_pseudo_header_checksum.sv
